>>> rtl/core/fct_pkg.sv
// ============================================================================
// fct_pkg: flow tracker / classifier shared definitions
// Table geometry, header constants and the records that pass between the
// front classifier, the item queue and the table back end.
// ============================================================================
`default_nettype none

package fct_pkg;

    // Connection table geometry
    localparam int TABLE_ENTRIES = 65536;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

    // Classified item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Header and protocol codes
    localparam logic [7:0]  HDR_BYTE_OK   = 8'h45;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [31:0] TIMEOUT_RESET = 32'd300;

    // Stream widths
    localparam int IN_TDATA_W  = 160;
    localparam int RESULT_W    = 84;
    localparam int OUT_TDATA_W = 88;

    // One classified packet on its way to the table
    typedef struct packed {
        logic              verdict;
        logic              drop_reason;
        logic              tracked;
        logic              src_nz;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       len;
        logic [31:0]       now;
    } queue_item_t;

    // One table slot as stored (source address kept only as "occupied")
    typedef struct packed {
        logic        occupied;
        logic [31:0] touch_time;
        logic [31:0] tx_bytes;
        logic [31:0] rx_bytes;
    } entry_t;

    // Result record, last field in the lowest bits
    typedef struct packed {
        logic [31:0] flow_rx_bytes;
        logic [31:0] flow_tx_bytes;
        logic [15:0] flow_slot;
        logic        flow_new;
        logic        tracked;
        logic        drop_reason;
        logic        verdict;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ipv4_flow_tracker_classifier.sv
// ============================================================================
// ipv4_flow_tracker_classifier: IPv4 flow tracker and classifier
// Classifies IPv4 header summaries and keeps a direct-mapped connection
// table of per-slot byte counts for TCP and UDP traffic.
// ============================================================================
// One packet summary in, one result out, sustained at one transfer per
// cycle while the output is not stalled and no table sweep runs. A
// packet's result passes from the classified-item queue through the
// registered table read, after which it sits in the output register.
// Table updates to the same slot on back-to-back packets are forwarded,
// so there is no stall for repeated hits. After reset the table is swept
// to zero, one slot per cycle, across all 65536 slots (the table depth);
// s_tready stays low during that sweep while flow_timeout writes are taken
// as usual. The user must write flow_timeout through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module ipv4_flow_tracker_classifier (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [31:0]                           cfg_wdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // version_ihl[7:0], ip_protocol[15:8], source_address[47:16],
    // dest_address[79:48], source_port[95:80], dest_port[111:96],
    // packet_length[127:112], current_time[159:128]
    input  wire logic [fct_pkg::IN_TDATA_W-1:0]        s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // verdict[0], drop_reason[1], tracked[2], flow_new[3],
    // flow_slot[19:4], flow_tx_bytes[51:20], flow_rx_bytes[83:52], pad
    output logic [fct_pkg::OUT_TDATA_W-1:0]            m_tdata
);
    import fct_pkg::*;

    logic [31:0] flow_timeout_reg;
    logic        clearing;
    logic        q_not_full;
    logic        q_not_empty;
    logic        push;
    logic        pop;
    queue_item_t push_item;
    queue_item_t head_item;

    // Idle timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            flow_timeout_reg <= cfg_wdata;
        end
    end

    fct_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clearing   (clearing),
        .q_not_full (q_not_full),
        .push       (push),
        .push_item  (push_item)
    );

    fct_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .not_empty  (q_not_empty),
        .not_full   (q_not_full)
    );

    fct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .flow_timeout (flow_timeout_reg),
        .head_item    (head_item),
        .q_not_empty  (q_not_empty),
        .pop          (pop),
        .clearing     (clearing),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/fct_front.sv
// ============================================================================
// fct_front: input handshake and packet classification
// Checks the header byte, picks tracked protocols and forms the table slot
// index, then pushes the classified item into the queue.
// ============================================================================
`default_nettype none

module fct_front (
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // version_ihl, ip_protocol, source_address, dest_address,
    // source_port, dest_port, packet_length, current_time
    input  wire logic [fct_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               clearing,
    input  wire logic                               q_not_full,
    output logic                                    push,
    output fct_pkg::queue_item_t                    push_item
);
    import fct_pkg::*;

    logic [7:0]  version_ihl;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] packet_length;
    logic [31:0] current_time;
    logic [31:0] hash;
    logic        hdr_ok;
    logic        proto_hit;

    // Field unpacking
    assign version_ihl    = s_tdata[7:0];
    assign ip_protocol    = s_tdata[15:8];
    assign source_address = s_tdata[47:16];
    assign dest_address   = s_tdata[79:48];
    assign source_port    = s_tdata[95:80];
    assign dest_port      = s_tdata[111:96];
    assign packet_length  = s_tdata[127:112];
    assign current_time   = s_tdata[159:128];

    // No intake while the table sweep runs or the queue is full
    assign s_tready = q_not_full && !clearing;
    assign push     = s_tvalid && s_tready;

    // Classification
    assign hdr_ok    = (version_ihl == HDR_BYTE_OK);
    assign proto_hit = (ip_protocol == PROTO_TCP) || (ip_protocol == PROTO_UDP);
    assign hash      = source_address ^ dest_address ^ {source_port, dest_port}
                       ^ {24'd0, ip_protocol};

    always_comb
    begin
        push_item.verdict     = hdr_ok;
        push_item.drop_reason = !hdr_ok;
        push_item.tracked     = hdr_ok && proto_hit;
        push_item.src_nz      = (source_address != 32'd0);
        push_item.slot        = hash[SLOT_W-1:0];
        push_item.len         = packet_length;
        push_item.now         = current_time;
    end

endmodule

`default_nettype wire

>>> rtl/core/fct_queue.sv
// ============================================================================
// fct_queue: classified item queue
// Small FIFO between the classifier and the table back end so that each
// side can stall on its own.
// ============================================================================
`default_nettype none

module fct_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire fct_pkg::queue_item_t  push_item,
    input  wire logic                  pop,
    output fct_pkg::queue_item_t       head_item,
    output logic                       not_empty,
    output logic                       not_full
);
    import fct_pkg::*;

    queue_item_t       item_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_item = item_mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fct_back.sv
// ============================================================================
// fct_back: connection table back end
// Holds the direct-mapped slot table, runs the read-modify-write for each
// tracked packet with forwarding between neighbors, and drives the result
// register. Sweeps the table to zero after reset.
// ============================================================================
`default_nettype none

module fct_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [31:0]                       flow_timeout,
    input  wire fct_pkg::queue_item_t              head_item,
    input  wire logic                              q_not_empty,
    output logic                                   pop,
    output logic                                   clearing,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // verdict, drop_reason, tracked, flow_new, flow_slot[15:0],
    // flow_tx_bytes[31:0], flow_rx_bytes[31:0], zero pad
    output logic [fct_pkg::OUT_TDATA_W-1:0]        m_tdata
);
    import fct_pkg::*;

    entry_t            table_mem [TABLE_ENTRIES];
    entry_t            rd_data_reg;

    logic              clearing_reg, clearing_next;
    logic [SLOT_W-1:0] clr_addr_reg, clr_addr_next;

    logic              b_valid_reg, b_valid_next;
    queue_item_t       b_item_reg;
    logic              fwd_hit_reg;
    entry_t            fwd_entry_reg;

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    entry_t            cur_entry;
    entry_t            new_entry;
    result_t           result;
    logic [31:0]       age;
    logic              fresh;
    logic              out_free;
    logic              b_fire;
    logic              upd_we;
    logic              fwd_hit;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    // Stage handshakes
    assign out_free = !out_valid_reg || m_tready;
    assign b_fire   = b_valid_reg && out_free;
    assign pop      = q_not_empty && !clearing_reg && (!b_valid_reg || b_fire);
    assign upd_we   = b_fire && b_item_reg.tracked;
    assign fwd_hit  = pop && upd_we && (b_item_reg.slot == head_item.slot);
    assign clearing = clearing_reg;

    // Slot update
    always_comb
    begin
        cur_entry = fwd_hit_reg ? fwd_entry_reg : rd_data_reg;
        age       = b_item_reg.now - cur_entry.touch_time;
        fresh     = !cur_entry.occupied || (age > flow_timeout);

        new_entry.touch_time = b_item_reg.now;
        if (fresh)
        begin
            new_entry.occupied = b_item_reg.src_nz;
            new_entry.tx_bytes = {16'd0, b_item_reg.len};
            new_entry.rx_bytes = '0;
        end
        else
        begin
            new_entry.occupied = cur_entry.occupied;
            new_entry.tx_bytes = cur_entry.tx_bytes;
            new_entry.rx_bytes = cur_entry.rx_bytes + {16'd0, b_item_reg.len};
        end

        result.verdict     = b_item_reg.verdict;
        result.drop_reason = b_item_reg.drop_reason;
        result.tracked     = b_item_reg.tracked;
        if (b_item_reg.tracked)
        begin
            result.flow_new      = fresh;
            result.flow_slot     = 16'(b_item_reg.slot);
            result.flow_tx_bytes = new_entry.tx_bytes;
            result.flow_rx_bytes = new_entry.rx_bytes;
        end
        else
        begin
            result.flow_new      = 1'b0;
            result.flow_slot     = '0;
            result.flow_tx_bytes = '0;
            result.flow_rx_bytes = '0;
        end
    end

    // Table write port: clearing sweep or slot update
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = upd_we;
            mem_waddr = b_item_reg.slot;
            mem_wdata = new_entry;
        end
    end

    // Slot table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_data_reg <= table_mem[head_item.slot];
        end
    end

    // Control next state
    always_comb
    begin
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = SLOT_W'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end

        b_valid_next = b_valid_reg;
        if (pop)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (b_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                fwd_hit_reg <= fwd_hit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_item_reg    <= head_item;
            fwd_entry_reg <= new_entry;
        end
        if (b_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_data_reg};

    // Checks
    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pop && !b_valid_reg)
        else $error("item entered the table stage during the clearing sweep");

    a_drop_untracked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.verdict |-> !out_data_reg.tracked)
        else $error("dropped packet marked as tracked");

    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.tracked |->
            !out_data_reg.flow_new && out_data_reg.flow_slot == 16'd0
            && out_data_reg.flow_tx_bytes == 32'd0)
        else $error("untracked result carries slot data");

    a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        pop && fwd_hit |=> b_valid_reg && $past(upd_we))
        else $error("forwarded entry without a table update");

endmodule

`default_nettype wire
